// ===== rtl/fmacl_pkg.sv =====
// Shared types and constants of the first-match IP access list.
// No dependencies; compiled first.
package fmacl_pkg;

  localparam int unsigned DEF_V4_RULES = 32;
  localparam int unsigned DEF_V6_RULES = 32;

  // Width of the reported rule position (low bits of the position only).
  localparam int unsigned IDX_W = 5;

  localparam int unsigned V4_W = 32;
  localparam int unsigned V6_W = 128;

  // Upper half of addr_lo for an IPv4-mapped IPv6 address (::ffff:a.b.c.d).
  localparam logic [31:0] V4_MAPPED_TAG = 32'h0000_ffff;

  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FAM_V4    = 2'd0,
    FAM_V6    = 2'd1,
    FAM_LOCAL = 2'd2,
    FAM_OTHER = 2'd3
  } family_e;

  typedef enum logic [1:0] {
    VERDICT_DECLINED  = 2'd0,
    VERDICT_ALLOWED   = 2'd1,
    VERDICT_FORBIDDEN = 2'd2
  } verdict_e;

  // Search token walking down a chain of rule cells.
  typedef struct packed {
    logic             busy;
    logic             hit;
    logic             deny;
    logic [IDX_W-1:0] idx;
  } tok_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [IDX_W-1:0] idx;
    logic             full;
  } res_t;

endpackage

// ===== rtl/fmacl_req_if.sv =====
// Request channel of the access list: valid/ready plus one request word.
// Depends on fmacl_pkg.
interface fmacl_req_if import fmacl_pkg::*; ();
  logic         valid;
  logic         ready;
  mode_e        mode;
  family_e      family;
  logic [63:0]  addr_hi;
  logic [63:0]  addr_lo;
  logic [63:0]  mask_hi;
  logic [63:0]  mask_lo;
  logic         deny_rule;

  modport source (
    output valid, mode, family, addr_hi, addr_lo, mask_hi, mask_lo, deny_rule,
    input  ready
  );
  modport sink (
    input  valid, mode, family, addr_hi, addr_lo, mask_hi, mask_lo, deny_rule,
    output ready
  );
endinterface

// ===== rtl/fmacl_rsp_if.sv =====
// Response channel of the access list: valid/ready plus one result word.
// Depends on fmacl_pkg.
interface fmacl_rsp_if import fmacl_pkg::*; ();
  logic             valid;
  logic             ready;
  verdict_e         verdict;
  logic [IDX_W-1:0] match_index;
  logic             table_full;

  modport source (output valid, verdict, match_index, table_full, input ready);
  modport sink   (input  valid, verdict, match_index, table_full, output ready);
endinterface

// ===== rtl/fmacl_cell.sv =====
// One rule cell: holds a single mask/address/deny rule, checks the passing
// search token against it and hands token and address on. Depends on fmacl_pkg.
module fmacl_cell import fmacl_pkg::*; #(
  parameter int unsigned W   = V4_W,
  parameter int unsigned CW  = 6,
  parameter int unsigned POS = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CW-1:0] count_i,
  input  logic          wr_en_i,
  input  logic [W-1:0]  wr_addr_i,
  input  logic [W-1:0]  wr_mask_i,
  input  logic          wr_deny_i,
  input  logic [W-1:0]  addr_i,
  input  tok_t          tok_i,
  output logic [W-1:0]  addr_o,
  output tok_t          tok_o
);

  localparam logic [CW-1:0]    POS_C = CW'(POS);
  localparam logic [IDX_W-1:0] POS_I = IDX_W'(POS);

  logic [W-1:0] mask_q, rule_q;
  logic         deny_q;
  logic [W-1:0] addr_q;
  tok_t         tok_q, tok_d;
  logic         active, match;

  // Rule store; written when this cell is the next free slot.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && count_i == POS_C) begin
      mask_q <= wr_mask_i;
      rule_q <= wr_addr_i & wr_mask_i;
      deny_q <= wr_deny_i;
    end
  end

  assign active = tok_i.busy && (POS_C < count_i);
  assign match  = (addr_i & mask_q) == rule_q;

  always_comb begin
    tok_d = tok_i;
    if (active && !tok_i.hit && match) begin
      tok_d.hit  = 1'b1;
      tok_d.deny = deny_q;
      tok_d.idx  = POS_I;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
  end

  assign tok_o  = tok_q;
  assign addr_o = addr_q;

endmodule

// ===== rtl/fmacl_chain.sv =====
// Ordered rule table as a row of N rule cells; the search token enters at
// cell 0 and leaves the last cell, registered in every cell on its way. Depends on fmacl_pkg, fmacl_cell.
module fmacl_chain import fmacl_pkg::*; #(
  parameter int unsigned N  = DEF_V4_RULES,
  parameter int unsigned W  = V4_W,
  parameter int unsigned CW = $clog2(DEF_V4_RULES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [CW-1:0] count_i,
  input  logic          wr_en_i,
  input  logic [W-1:0]  wr_addr_i,
  input  logic [W-1:0]  wr_mask_i,
  input  logic          wr_deny_i,
  input  logic [W-1:0]  addr_i,
  input  tok_t          tok_i,
  output tok_t          tok_o
);

  tok_t         tok  [N+1];
  logic [W-1:0] addr [N+1];

  assign tok[0]  = tok_i;
  assign addr[0] = addr_i;

  for (genvar i = 0; i < N; i++) begin : g_cell
    fmacl_cell #(
      .W   (W),
      .CW  (CW),
      .POS (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .count_i   (count_i),
      .wr_en_i   (wr_en_i),
      .wr_addr_i (wr_addr_i),
      .wr_mask_i (wr_mask_i),
      .wr_deny_i (wr_deny_i),
      .addr_i    (addr[i]),
      .tok_i     (tok[i]),
      .addr_o    (addr[i+1]),
      .tok_o     (tok[i+1])
    );
  end

  assign tok_o = tok[N];

endmodule

// ===== rtl/first_match_ip_acl_unit.sv =====
// First-match IPv4/IPv6 access list, top level with the request sequencer.
// Depends on fmacl_pkg, fmacl_req_if, fmacl_rsp_if, fmacl_chain.
//
// The block keeps two ordered rule tables, IPv4 (V4_RULES rules) and IPv6
// (V6_RULES rules), each a row of rule cells, plus the first local-socket
// rule. A request word appends a rule, clears all tables, looks up an
// address or does nothing; every request gives exactly one response word.
// A lookup is sent as a token down the chosen row, one cell per cycle, and
// the first cell whose masked address matches marks the token; the token
// passes all N cells of the row before the search state takes its result,
// N being that table's rule count parameter (not its fill level). Appends,
// clears, no-ops, local-socket lookups and lookups of an empty table or of
// another family go straight to the hold state. One request is worked on
// at a time; the next one is accepted as soon as the previous response
// sits in the output register, even if it has not been taken.
// IPv4-mapped IPv6 addresses (::ffff:a.b.c.d) search the IPv4 table when
// it holds any rule. An append to a full table is dropped and reported by
// table_full. No clearing sweep after reset is needed.
module first_match_ip_acl_unit import fmacl_pkg::*; #(
  parameter int unsigned V4_RULES = DEF_V4_RULES,
  parameter int unsigned V6_RULES = DEF_V6_RULES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fmacl_req_if.sink   req_i,
  fmacl_rsp_if.source rsp_o
);

  localparam int unsigned CW4 = $clog2(V4_RULES + 1);
  localparam int unsigned CW6 = $clog2(V6_RULES + 1);
  localparam logic [CW4-1:0] V4_FULL = CW4'(V4_RULES);
  localparam logic [CW6-1:0] V6_FULL = CW6'(V6_RULES);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_HOLD   = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Table fill levels and local-socket record
  logic [CW4-1:0] v4_cnt_q, v4_cnt_d;
  logic [CW6-1:0] v6_cnt_q, v6_cnt_d;
  logic           loc_present_q, loc_present_d;
  logic           loc_deny_q, loc_deny_d;

  // Query launch into a row
  logic        v4_go_q, v4_go_d, v6_go_q, v6_go_d;
  logic [63:0] qry_hi_q, qry_lo_q;

  // Pending result and output register
  res_t res_q, res_d;
  res_t out_q;
  logic out_valid_q;

  logic accept, v4_full, v6_full, mapped, out_free;
  logic v4_wr_en, v6_wr_en;
  tok_t v4_tok_in, v6_tok_in, v4_tok_out, v6_tok_out, tail;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign v4_full     = (v4_cnt_q == V4_FULL);
  assign v6_full     = (v6_cnt_q == V6_FULL);
  assign mapped      = (req_i.addr_hi == '0) && (req_i.addr_lo[63:32] == V4_MAPPED_TAG);
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign v4_wr_en = accept && req_i.mode == MODE_APPEND && req_i.family == FAM_V4 && !v4_full;
  assign v6_wr_en = accept && req_i.mode == MODE_APPEND && req_i.family == FAM_V6 && !v6_full;

  always_comb begin
    v4_tok_in      = '0;
    v4_tok_in.busy = v4_go_q;
    v6_tok_in      = '0;
    v6_tok_in.busy = v6_go_q;
  end

  fmacl_chain #(
    .N  (V4_RULES),
    .W  (V4_W),
    .CW (CW4)
  ) u_v4_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .count_i   (v4_cnt_q),
    .wr_en_i   (v4_wr_en),
    .wr_addr_i (req_i.addr_lo[V4_W-1:0]),
    .wr_mask_i (req_i.mask_lo[V4_W-1:0]),
    .wr_deny_i (req_i.deny_rule),
    .addr_i    (qry_lo_q[V4_W-1:0]),
    .tok_i     (v4_tok_in),
    .tok_o     (v4_tok_out)
  );

  fmacl_chain #(
    .N  (V6_RULES),
    .W  (V6_W),
    .CW (CW6)
  ) u_v6_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .count_i   (v6_cnt_q),
    .wr_en_i   (v6_wr_en),
    .wr_addr_i ({req_i.addr_hi, req_i.addr_lo}),
    .wr_mask_i ({req_i.mask_hi, req_i.mask_lo}),
    .wr_deny_i (req_i.deny_rule),
    .addr_i    ({qry_hi_q, qry_lo_q}),
    .tok_i     (v6_tok_in),
    .tok_o     (v6_tok_out)
  );

  // Only one row carries a token at a time.
  assign tail = v4_tok_out.busy ? v4_tok_out : v6_tok_out;

  always_comb begin
    state_d       = state_q;
    v4_cnt_d      = v4_cnt_q;
    v6_cnt_d      = v6_cnt_q;
    loc_present_d = loc_present_q;
    loc_deny_d    = loc_deny_q;
    v4_go_d       = 1'b0;
    v6_go_d       = 1'b0;
    res_d         = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d   = '0;
          state_d = ST_HOLD;
          case (req_i.mode)
            MODE_LOOKUP: begin
              case (req_i.family)
                FAM_V4: begin
                  if (v4_cnt_q != '0) begin
                    v4_go_d = 1'b1;
                    state_d = ST_SEARCH;
                  end
                end
                FAM_V6: begin
                  if (mapped && v4_cnt_q != '0) begin
                    v4_go_d = 1'b1;
                    state_d = ST_SEARCH;
                  end else if (v6_cnt_q != '0) begin
                    v6_go_d = 1'b1;
                    state_d = ST_SEARCH;
                  end
                end
                FAM_LOCAL: begin
                  if (loc_present_q) begin
                    res_d.verdict = loc_deny_q ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
                  end
                end
                default: ;
              endcase
            end
            MODE_APPEND: begin
              case (req_i.family)
                FAM_V4: begin
                  if (v4_full) res_d.full = 1'b1;
                  else         v4_cnt_d   = v4_cnt_q + 1'b1;
                end
                FAM_V6: begin
                  if (v6_full) res_d.full = 1'b1;
                  else         v6_cnt_d   = v6_cnt_q + 1'b1;
                end
                FAM_LOCAL: begin
                  if (!loc_present_q) begin
                    loc_present_d = 1'b1;
                    loc_deny_d    = req_i.deny_rule;
                  end
                end
                default: ;
              endcase
            end
            MODE_CLEAR: begin
              v4_cnt_d      = '0;
              v6_cnt_d      = '0;
              loc_present_d = 1'b0;
              loc_deny_d    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        // wait for the token to leave the last cell
        if (tail.busy) begin
          res_d.full = 1'b0;
          if (tail.hit) begin
            res_d.verdict = tail.deny ? VERDICT_FORBIDDEN : VERDICT_ALLOWED;
            res_d.idx     = tail.idx;
          end else begin
            res_d.verdict = VERDICT_DECLINED;
            res_d.idx     = '0;
          end
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      v4_cnt_q      <= '0;
      v6_cnt_q      <= '0;
      loc_present_q <= 1'b0;
      loc_deny_q    <= 1'b0;
      v4_go_q       <= 1'b0;
      v6_go_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      v4_cnt_q      <= v4_cnt_d;
      v6_cnt_q      <= v6_cnt_d;
      loc_present_q <= loc_present_d;
      loc_deny_q    <= loc_deny_d;
      v4_go_q       <= v4_go_d;
      v6_go_q       <= v6_go_d;
      if (state_q == ST_HOLD && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      qry_hi_q <= req_i.addr_hi;
      qry_lo_q <= req_i.addr_lo;
    end
    if (state_q == ST_HOLD && out_free) begin
      out_q <= res_q;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.verdict     = out_q.verdict;
  assign rsp_o.match_index = out_q.idx;
  assign rsp_o.table_full  = out_q.full;

endmodule
